// ----- rtl/base64_stream_decoder_core_defines.svh -----
// Assertion macros for the base64 stream decoder checker.
// Needs clk and arst_n in the scope of use.
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/b64d_pkg.sv -----
// Shared types and constants for the base64 stream decoder.
// No dependencies.
package b64d_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR      = 2'd1;
	localparam logic [1:0] ST_DATA_AFTER_PAD = 2'd2;
	localparam logic [1:0] ST_TRAILING_BITS = 2'd3;

	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_D0    = 8'h30;
	localparam logic [7:0] CH_D9    = 8'h39;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] LC_OFS   = 8'd26;
	localparam logic [7:0] DIG_OFS  = 8'd52;
	localparam logic [5:0] SYM_PLUS  = 6'd62;
	localparam logic [5:0] SYM_SLASH = 6'd63;

	typedef enum logic [2:0] {
		KIND_DATA   = 3'd0,
		KIND_PAD    = 3'd1,
		KIND_SKIP   = 3'd2,
		KIND_BAD    = 3'd3,
		KIND_FINISH = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] sym;
	} item_t;

endpackage

// ----- rtl/b64d_queue.sv -----
// Short word queue between decoder front and back.
// Depends on b64d_pkg.
module b64d_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64d_pkg::item_t   push_item,
	output logic              full,
	input  logic              pop,
	output logic              q_valid,
	output b64d_pkg::item_t   q_item
);

	b64d_pkg::item_t                    entries_q [b64d_pkg::QDEPTH];
	logic [b64d_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [b64d_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [b64d_pkg::QCNT_W-1:0]        count_q;

	function automatic logic [b64d_pkg::QPTR_W-1:0] ptr_next(
		input logic [b64d_pkg::QPTR_W-1:0] p);
		if (p == b64d_pkg::QPTR_W'(b64d_pkg::QDEPTH - 1))
			return '0;
		return p + b64d_pkg::QPTR_W'(1);
	endfunction

	assign full    = (count_q == b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + b64d_pkg::QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - b64d_pkg::QCNT_W'(1);
		end
	end

endmodule

// ----- rtl/b64d_front.sv -----
// Input side: takes words, classifies characters into symbols, feeds the queue.
// Depends on b64d_pkg.
module b64d_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             op,
	input  logic [7:0]       in_char,
	input  logic             q_full,
	output logic             push,
	output b64d_pkg::item_t  push_item
);

	function automatic b64d_pkg::item_t classify(input logic f, input logic [7:0] ch);
		b64d_pkg::item_t it;
		it.kind = b64d_pkg::KIND_BAD;
		it.sym  = '0;
		if (f) begin
			it.kind = b64d_pkg::KIND_FINISH;
		end else begin
			case (ch) inside
				[b64d_pkg::CH_UC_A:b64d_pkg::CH_UC_Z]: begin
					it.kind = b64d_pkg::KIND_DATA;
					it.sym  = 6'(ch - b64d_pkg::CH_UC_A);
				end
				[b64d_pkg::CH_LC_A:b64d_pkg::CH_LC_Z]: begin
					it.kind = b64d_pkg::KIND_DATA;
					it.sym  = 6'(ch - b64d_pkg::CH_LC_A + b64d_pkg::LC_OFS);
				end
				[b64d_pkg::CH_D0:b64d_pkg::CH_D9]: begin
					it.kind = b64d_pkg::KIND_DATA;
					it.sym  = 6'(ch - b64d_pkg::CH_D0 + b64d_pkg::DIG_OFS);
				end
				b64d_pkg::CH_PLUS: begin
					it.kind = b64d_pkg::KIND_DATA;
					it.sym  = b64d_pkg::SYM_PLUS;
				end
				b64d_pkg::CH_SLASH: begin
					it.kind = b64d_pkg::KIND_DATA;
					it.sym  = b64d_pkg::SYM_SLASH;
				end
				b64d_pkg::CH_PAD: begin
					it.kind = b64d_pkg::KIND_PAD;
				end
				b64d_pkg::CH_SP, b64d_pkg::CH_TAB, b64d_pkg::CH_CR, b64d_pkg::CH_LF: begin
					it.kind = b64d_pkg::KIND_SKIP;
				end
				default: begin
					it.kind = b64d_pkg::KIND_BAD;
				end
			endcase
		end
		return it;
	endfunction

	assign in_ready  = !q_full;
	assign push      = in_valid && !q_full;
	assign push_item = classify(op, in_char);

endmodule

// ----- rtl/b64d_back.sv -----
// Execution side: bit accumulator, padding and error state, output register.
// Depends on b64d_pkg.
module b64d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  b64d_pkg::item_t  q_item,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             byte_valid,
	output logic [7:0]       data_byte,
	output logic             done_res,
	output logic [1:0]       status
);

	logic [11:0] acc_q;
	logic [2:0]  bits_q;
	logic        pad_q;
	logic [1:0]  err_q;

	logic        out_valid_q;
	logic        byte_valid_q;
	logic [7:0]  data_byte_q;
	logic        done_q;
	logic [1:0]  status_q;

	logic [11:0] acc_d;
	logic [2:0]  bits_d;
	logic        pad_d;
	logic [1:0]  err_d;
	logic        bv_d;
	logic [7:0]  byte_d;
	logic        done_d;
	logic [1:0]  status_d;

	logic [11:0] acc_sh;
	logic [3:0]  n_sum;
	logic [3:0]  n_adj;
	logic [5:0]  mask;

	assign pop = q_valid && (!out_valid_q || out_ready);

	always_comb begin
		acc_d    = acc_q;
		bits_d   = bits_q;
		pad_d    = pad_q;
		err_d    = err_q;
		bv_d     = 1'b0;
		byte_d   = '0;
		done_d   = 1'b0;
		status_d = err_q;
		acc_sh   = {acc_q[5:0], q_item.sym};
		n_sum    = {1'b0, bits_q} + 4'd6;
		n_adj    = n_sum - 4'd8;
		mask     = 6'((7'd1 << bits_q) - 7'd1);
		if (q_item.kind == b64d_pkg::KIND_FINISH) begin
			done_d = 1'b1;
			if (err_q == b64d_pkg::ST_OK && bits_q != '0 && (acc_q[5:0] & mask) != '0)
				status_d = b64d_pkg::ST_TRAILING_BITS;
			acc_d  = '0;
			bits_d = '0;
			pad_d  = 1'b0;
			err_d  = b64d_pkg::ST_OK;
		end else begin
			if (err_q == b64d_pkg::ST_OK) begin
				case (q_item.kind)
					b64d_pkg::KIND_BAD: err_d = b64d_pkg::ST_BAD_CHAR;
					b64d_pkg::KIND_PAD: pad_d = 1'b1;
					b64d_pkg::KIND_DATA: begin
						if (pad_q) begin
							err_d = b64d_pkg::ST_DATA_AFTER_PAD;
						end else begin
							acc_d = acc_sh;
							if (n_sum >= 4'd8) begin
								bv_d   = 1'b1;
								byte_d = 8'(acc_sh >> n_adj);
								bits_d = n_adj[2:0];
							end else begin
								bits_d = n_sum[2:0];
							end
						end
					end
					default: ;
				endcase
			end
			status_d = err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			bits_q      <= '0;
			pad_q       <= 1'b0;
			err_q       <= b64d_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q  <= acc_d;
				bits_q <= bits_d;
				pad_q  <= pad_d;
				err_q  <= err_d;
			end
			if (pop)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_valid_q <= bv_d;
			data_byte_q  <= byte_d;
			done_q       <= done_d;
			status_q     <= status_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_valid = byte_valid_q;
	assign data_byte  = data_byte_q;
	assign done_res   = done_q;
	assign status     = status_q;

endmodule

// ----- rtl/base64_stream_decoder_core.sv -----
// Top level of the base64 stream decoder: front, queue, back.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    op, in_char
//   out      out_valid/out_ready  byte_valid, data_byte, done_res, status
//
// One word per cycle unless out stalls; each word is queued, then output-registered.
// The two-word queue decouples classification from the accumulator update.
// in_ready drops only when the queue is full; out stalls hold the output register.
// arst_n clears accumulator, flags, error code, queue and output valid.
module base64_stream_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic [7:0] in_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] data_byte,
	output logic       done_res,
	output logic [1:0] status
);

	logic            q_full;
	logic            push;
	b64d_pkg::item_t push_item;
	logic            pop;
	logic            q_valid;
	b64d_pkg::item_t q_item;

	b64d_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.in_char   (in_char),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	b64d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_valid (byte_valid),
		.data_byte  (data_byte),
		.done_res   (done_res),
		.status     (status)
	);

endmodule

// ----- rtl/b64d_checker.sv -----
// Port-level checker for the base64 stream decoder, bound to the top level.
// Depends on base64_stream_decoder_core_defines.svh and b64d_pkg.
`include "base64_stream_decoder_core_defines.svh"

module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       op,
	input logic [7:0] in_char,
	input logic       out_valid,
	input logic       out_ready,
	input logic       byte_valid,
	input logic [7:0] data_byte,
	input logic       done_res,
	input logic [1:0] status
);

	`B64D_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
		in_valid && $stable(op) && $stable(in_char),
		"input word changed while stalled")
	`B64D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(byte_valid) && $stable(data_byte) && $stable(done_res)
			&& $stable(status),
		"output word changed while stalled")
	`B64D_ASSERT_NOW(a_no_byte_on_done, out_valid && done_res,
		!byte_valid && data_byte == 8'd0,
		"finish word carries a byte")
	`B64D_ASSERT_NOW(a_zero_idle_byte, out_valid && !byte_valid,
		data_byte == 8'd0,
		"data byte nonzero without byte_valid")
	`B64D_ASSERT_NOW(a_no_byte_on_err, out_valid && !done_res && status != b64d_pkg::ST_OK,
		!byte_valid,
		"byte emitted with error held")

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (.*);
